// ===== design/gfpd_pkg.sv =====
// shared constants, types and a helper function for the gps frame parser
`timescale 1ns / 1ps

package gfpd_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'h55;
    localparam logic [7:0] SYNC_SECOND = 8'hAA;
    localparam logic [7:0] ID_POSITION = 8'h10;
    localparam logic [7:0] ID_COMPASS  = 8'h20;

    localparam logic [5:0] LEN_POSITION      = 6'd58;
    localparam logic [5:0] LEN_COMPASS       = 6'd6;
    localparam logic [5:0] MASK_INDEX        = 6'd55;
    localparam logic [5:0] COMPASS_MASK_BYTE = 6'd4;

    localparam int CHAIN_LEN = 58;
    localparam int POS_HEAD  = int'(LEN_POSITION) - 1;
    localparam int CMP_HEAD  = int'(LEN_COMPASS) - 1;
    localparam int POS_MASK  = int'(LEN_POSITION) - 1 - int'(MASK_INDEX);
    localparam int CMP_MASK  = int'(LEN_COMPASS) - 1 - int'(COMPASS_MASK_BYTE);

    localparam logic MSG_POSITION = 1'b0;
    localparam logic MSG_COMPASS  = 1'b1;

    // fixed read points on the byte chain
    typedef struct packed {
        logic [7:0] pos_head;
        logic [7:0] cmp_head;
        logic [7:0] pos_mask;
        logic [7:0] cmp_mask;
    } chain_taps_t;

    function automatic logic [7:0] compass_mask(input logic [7:0] b);
        logic [7:0] t;
        t = ((b ^ (b >> 4)) & 8'h0F) | ((b << 3) & 8'hF0);
        t = t ^ {b[0], 3'b000, b[0], 3'b000};
        return t;
    endfunction

endpackage

// ===== design/gfpd_cell.sv =====
// one byte cell of the payload chain
`timescale 1ns / 1ps

module gfpd_cell (
    input  logic       aclk,
    input  logic       shift_en,
    input  logic [7:0] din,
    output logic [7:0] dout
);

    logic [7:0] byte_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            byte_reg <= din;
        end
    end

    assign dout = byte_reg;

endmodule

// ===== design/gfpd_chain.sv =====
// row of byte cells, new bytes enter at cell 0 and move up one cell per shift
`timescale 1ns / 1ps

module gfpd_chain
    import gfpd_pkg::*;
(
    input  logic        aclk,
    input  logic        shift_en,
    input  logic [7:0]  din,
    output chain_taps_t taps
);

    logic [7:0] link [CHAIN_LEN+1];

    assign link[0] = din;

    for (genvar i = 0; i < CHAIN_LEN; i++) begin : g_cell
        gfpd_cell u_cell (
            .aclk     (aclk),
            .shift_en (shift_en),
            .din      (link[i]),
            .dout     (link[i+1])
        );
    end

    // cell k drives link[k+1]
    assign taps.pos_head = link[POS_HEAD+1];
    assign taps.cmp_head = link[CMP_HEAD+1];
    assign taps.pos_mask = link[POS_MASK+1];
    assign taps.cmp_mask = link[CMP_MASK+1];

endmodule

// ===== design/gps_frame_parser_demask.sv =====
// top level of the gps frame parser with fletcher check and payload demasking
//
//  channel | dir | tdata                                   | tuser       | tlast
//  s_      | in  | [7:0] rx_byte                           | -           | -
//  m_      | out | [5:0] byte_index, [13:6] data_byte, 0s  | [0] msg_kind| last
//
// one input byte is taken per cycle while hunting, reading the header, the
// payload and the two checksum bytes
// after a good second checksum byte the payload leaves the byte chain at one
// byte per cycle while m_tready allows: 58 bytes for a position frame, 6 for a
// compass frame, and s_tready stays low until the last byte is loaded
// the output register lets a finished byte wait while the next frame arrives
// synchronous active-low reset puts the parser into sync hunt; the chain
// holds no reset value, every read byte was written in the same frame
// m_tready low stalls emission in place without losing or repeating a byte
`timescale 1ns / 1ps

module gps_frame_parser_demask
    import gfpd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [5:0] byte_index, [13:6] data_byte, [15:14] zero
    output logic        m_tuser,   // [0] msg_kind
    output logic        m_tlast
);

    typedef enum logic [3:0] {
        PH_HUNT1,
        PH_HUNT2,
        PH_ID,
        PH_LEN,
        PH_DATA,
        PH_CK1,
        PH_CK2,
        PH_SKIP,
        PH_EMIT
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;
    logic        kind_reg, kind_next;
    logic [5:0]  count_reg, count_next;
    logic [7:0]  mask_reg, mask_next;
    logic [5:0]  idx_reg, idx_next;
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_data_reg, m_data_next;
    logic [5:0]  m_idx_reg, m_idx_next;
    logic        m_kind_reg, m_kind_next;
    logic        m_last_reg, m_last_next;

    logic        s_fire;
    logic        m_load;
    logic        shift_en;
    chain_taps_t taps;
    logic [7:0]  fold_a;
    logic [5:0]  frame_len;
    logic [7:0]  head_byte;
    logic        keep_byte;
    logic        last_byte;

    assign s_tready = (phase_reg != PH_EMIT);
    assign s_fire   = s_tvalid && s_tready;
    // next payload byte may enter the output register
    assign m_load   = (phase_reg == PH_EMIT) && (!m_valid_reg || m_tready);
    assign shift_en = (s_fire && (phase_reg == PH_DATA)) || m_load;

    gfpd_chain u_chain (
        .aclk     (aclk),
        .shift_en (shift_en),
        .din      (s_tdata),
        .taps     (taps)
    );

    // fletcher running sum
    assign fold_a    = sum_a_reg + s_tdata;
    assign frame_len = (kind_reg == MSG_COMPASS) ? LEN_COMPASS : LEN_POSITION;

    // emission side: oldest byte sits at the head cell for the frame length
    assign head_byte = (kind_reg == MSG_COMPASS) ? taps.cmp_head : taps.pos_head;
    assign keep_byte = (kind_reg == MSG_COMPASS) ? (idx_reg == COMPASS_MASK_BYTE)
                     : ((idx_reg == MASK_INDEX) || (idx_reg >= (LEN_POSITION - 6'd2)));
    assign last_byte = (idx_reg == (frame_len - 6'd1));

    always_comb begin
        phase_next   = phase_reg;
        sum_a_next   = sum_a_reg;
        sum_b_next   = sum_b_reg;
        kind_next    = kind_reg;
        count_next   = count_reg;
        mask_next    = mask_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_idx_next   = m_idx_reg;
        m_kind_next  = m_kind_reg;
        m_last_next  = m_last_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        if (s_fire) begin
            case (phase_reg)
                PH_HUNT1: begin
                    if (s_tdata == SYNC_FIRST) begin
                        phase_next = PH_HUNT2;
                    end
                end
                PH_HUNT2: begin
                    if (s_tdata == SYNC_SECOND) begin
                        sum_a_next = 8'd0;
                        sum_b_next = 8'd0;
                        phase_next = PH_ID;
                    end else begin
                        phase_next = PH_HUNT1;
                    end
                end
                PH_ID: begin
                    sum_a_next = fold_a;
                    sum_b_next = sum_b_reg + fold_a;
                    if (s_tdata == ID_POSITION) begin
                        kind_next  = MSG_POSITION;
                        phase_next = PH_LEN;
                    end else if (s_tdata == ID_COMPASS) begin
                        kind_next  = MSG_COMPASS;
                        phase_next = PH_LEN;
                    end else begin
                        phase_next = PH_SKIP;
                    end
                end
                PH_LEN: begin
                    if (s_tdata == {2'b00, frame_len}) begin
                        count_next = 6'd0;
                        sum_a_next = fold_a;
                        sum_b_next = sum_b_reg + fold_a;
                        phase_next = PH_DATA;
                    end else begin
                        phase_next = PH_HUNT1;
                    end
                end
                PH_DATA: begin
                    count_next = count_reg + 6'd1;
                    sum_a_next = fold_a;
                    sum_b_next = sum_b_reg + fold_a;
                    if ((count_reg + 6'd1) >= frame_len) begin
                        phase_next = PH_CK1;
                    end
                end
                PH_CK1: begin
                    phase_next = (s_tdata == sum_a_reg) ? PH_CK2 : PH_HUNT1;
                end
                PH_CK2: begin
                    if (s_tdata == sum_b_reg) begin
                        // mask byte still sits at a fixed cell, chain is frozen here
                        mask_next  = (kind_reg == MSG_COMPASS) ?
                                     compass_mask(taps.cmp_mask) : taps.pos_mask;
                        idx_next   = 6'd0;
                        phase_next = PH_EMIT;
                    end else begin
                        phase_next = PH_HUNT1;
                    end
                end
                default: begin
                    phase_next = PH_HUNT1;
                end
            endcase
        end

        if (m_load) begin
            m_valid_next = 1'b1;
            m_data_next  = keep_byte ? head_byte : (head_byte ^ mask_reg);
            m_idx_next   = idx_reg;
            m_kind_next  = kind_reg;
            m_last_next  = last_byte;
            idx_next     = idx_reg + 6'd1;
            if (last_byte) begin
                phase_next = PH_HUNT1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT1;
            sum_a_reg   <= 8'd0;
            sum_b_reg   <= 8'd0;
            kind_reg    <= 1'b0;
            count_reg   <= 6'd0;
            idx_reg     <= 6'd0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            sum_a_reg   <= sum_a_next;
            sum_b_reg   <= sum_b_next;
            kind_reg    <= kind_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
        mask_reg   <= mask_next;
        m_data_reg <= m_data_next;
        m_idx_reg  <= m_idx_next;
        m_kind_reg <= m_kind_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_data_reg, m_idx_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    // last byte of a frame carries the final index for its kind
    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |->
            ((m_tuser == MSG_POSITION && m_tdata[5:0] == (LEN_POSITION - 6'd1)) ||
             (m_tuser == MSG_COMPASS && m_tdata[5:0] == (LEN_COMPASS - 6'd1))))
        else $error("last byte index does not match frame kind");

    // a frame streams out without gaps and with rising indexes
    a_index_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=>
            (m_tvalid && m_tdata[5:0] == ($past(m_tdata[5:0]) + 6'd1)))
        else $error("payload index did not advance by one");

    // no input is taken while a frame is still being emitted
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> !s_tready)
        else $error("input taken in the middle of frame emission");

endmodule
